[rtl/core/sgp_pkg.sv]
`default_nettype none
package sgp_pkg;

    localparam int unsigned PosW   = 12;
    localparam int unsigned FracW  = 10;
    localparam int unsigned FrameW = 2;
    localparam int unsigned HoldFramesDefault = 2;

    localparam logic [FracW-1:0] FX_CENTRE = 10'd512;
    localparam logic [FracW-1:0] FX_HIGH   = 10'd922;
    localparam logic [FracW-1:0] FX_LOW    = 10'd102;

    localparam logic [1:0] OP_DOWN = 2'd0;
    localparam logic [1:0] OP_UP   = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic CFG_ENABLE   = 1'b0;
    localparam logic CFG_MIN_DIST = 1'b1;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_DOWN = 2'd1,
        K_UP   = 2'd2,
        K_TICK = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind           kind;
        logic [PosW-1:0] a;
        logic [PosW-1:0] b;
        logic            dx_neg;
        logic            dy_neg;
    } t_mid;

    typedef struct packed {
        logic [FracW-1:0] x;
        logic [FracW-1:0] y;
    } t_point;

    typedef struct packed {
        logic   touch_down;
        t_point pos;
        logic   button_update;
        logic   button_pressed;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/swipe_gesture_player.sv]
// Swipe gesture player: turns finger down, finger up and frame tick beats into
// emulated touchpad contact beats. The block accepts one beat per clock cycle
// while the output side is not stalled. The accepting edge registers the
// travel from the stored start point; a later edge, once the output stage can
// take the beat, squares and compares it to pick the sector endpoint, advance
// the playback state and register any result.
// One stage of slack lets a new beat enter while a result waits on the output.
// Configuration writes must be made only while no beat is in flight.
`default_nettype none
module swipe_gesture_player #(
    parameter int unsigned HOLD_FRAMES = sgp_pkg::HoldFramesDefault
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_index,
    input  wire logic [sgp_pkg::PosW-1:0]   i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_opcode,
    input  wire logic [sgp_pkg::PosW-1:0]   i_pos_x,
    input  wire logic [sgp_pkg::PosW-1:0]   i_pos_y,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_touch_down,
    output logic [sgp_pkg::FracW-1:0]       o_touch_x,
    output logic [sgp_pkg::FracW-1:0]       o_touch_y,
    output logic                            o_button_update,
    output logic                            o_button_pressed
);

    logic                     r_swipe_enable;
    logic [sgp_pkg::PosW-1:0] r_min_distance;
    logic                     clear_held;
    logic                     adv;
    logic                     mid_valid;
    sgp_pkg::t_mid            mid;
    sgp_pkg::t_point          end_pt;
    sgp_pkg::t_result         result;

    assign clear_held = i_cfg_we && i_cfg_index == sgp_pkg::CFG_ENABLE && !i_cfg_data[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swipe_enable <= 1'b0;
            r_min_distance <= sgp_pkg::PosW'(15);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sgp_pkg::CFG_ENABLE:   r_swipe_enable <= i_cfg_data[0];
                sgp_pkg::CFG_MIN_DIST: r_min_distance <= i_cfg_data;
                default:               r_swipe_enable <= r_swipe_enable;
            endcase
        end
    end

    sgp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_clear_held (clear_held),
        .i_adv        (adv),
        .o_mid_valid  (mid_valid),
        .o_mid        (mid)
    );

    sgp_sector u_sector (
        .i_mid          (mid),
        .i_min_distance (r_min_distance),
        .o_end          (end_pt)
    );

    sgp_player #(
        .HOLD_FRAMES (HOLD_FRAMES)
    ) u_player (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .i_mid       (mid),
        .i_end       (end_pt),
        .i_enable    (r_swipe_enable),
        .i_out_ready (i_out_ready),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_touch_down     = result.touch_down;
    assign o_touch_x        = result.pos.x;
    assign o_touch_y        = result.pos.y;
    assign o_button_update  = result.button_update;
    assign o_button_pressed = result.button_pressed;

`ifndef SYNTHESIS
    a_button_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_button_update |-> o_button_pressed == o_touch_down)
        else $error("button level does not follow contact state");

    a_move_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_button_update |-> o_touch_down && !o_button_pressed)
        else $error("move beat without contact");

    a_press_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_touch_down && o_button_update |->
            o_touch_x == sgp_pkg::FX_CENTRE && o_touch_y == sgp_pkg::FX_CENTRE)
        else $error("press beat away from centre");

    a_mid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_valid && !adv |=> mid_valid)
        else $error("stalled middle stage lost its beat");
`endif

endmodule
`default_nettype wire

[rtl/core/sgp_front.sv]
`default_nettype none
module sgp_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [1:0]                i_opcode,
    input  wire logic [sgp_pkg::PosW-1:0]  i_pos_x,
    input  wire logic [sgp_pkg::PosW-1:0]  i_pos_y,
    input  wire logic                      i_clear_held,
    input  wire logic                      i_adv,
    output logic                           o_mid_valid,
    output sgp_pkg::t_mid                  o_mid
);

    logic [sgp_pkg::PosW-1:0] r_start_x;
    logic [sgp_pkg::PosW-1:0] r_start_y;
    logic                     r_held;
    logic                     r_mid_valid;
    sgp_pkg::t_mid            r_mid;
    sgp_pkg::t_mid            n_mid;
    logic                     accept;
    logic                     x_lt;
    logic                     y_lt;

    assign o_in_ready = !r_mid_valid || i_adv;
    assign accept     = i_in_valid && o_in_ready;
    assign x_lt       = i_pos_x < r_start_x;
    assign y_lt       = i_pos_y < r_start_y;

    always_comb begin
        n_mid.a      = x_lt ? (r_start_x - i_pos_x) : (i_pos_x - r_start_x);
        n_mid.b      = y_lt ? (r_start_y - i_pos_y) : (i_pos_y - r_start_y);
        n_mid.dx_neg = x_lt;
        n_mid.dy_neg = y_lt;
        case (i_opcode)
            sgp_pkg::OP_DOWN: n_mid.kind = sgp_pkg::K_DOWN;
            sgp_pkg::OP_UP:   n_mid.kind = r_held ? sgp_pkg::K_UP : sgp_pkg::K_NONE;
            sgp_pkg::OP_TICK: n_mid.kind = sgp_pkg::K_TICK;
            default:          n_mid.kind = sgp_pkg::K_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= 1'b0;
            r_mid_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_mid_valid <= 1'b1;
            end else if (i_adv) begin
                r_mid_valid <= 1'b0;
            end
            if (i_clear_held) begin
                r_held <= 1'b0;
            end else if (accept && i_opcode == sgp_pkg::OP_DOWN) begin
                r_held <= 1'b1;
            end else if (accept && i_opcode == sgp_pkg::OP_UP) begin
                r_held <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mid <= n_mid;
        end
        if (accept && i_opcode == sgp_pkg::OP_DOWN) begin
            r_start_x <= i_pos_x;
            r_start_y <= i_pos_y;
        end
    end

    assign o_mid_valid = r_mid_valid;
    assign o_mid       = r_mid;

endmodule
`default_nettype wire

[rtl/core/sgp_sector.sv]
`default_nettype none
module sgp_sector (
    input  wire sgp_pkg::t_mid             i_mid,
    input  wire logic [sgp_pkg::PosW-1:0]  i_min_distance,
    output sgp_pkg::t_point                o_end
);

    logic [sgp_pkg::PosW:0]       sum_ab;
    logic [2*sgp_pkg::PosW-1:0]   a2;
    logic [2*sgp_pkg::PosW-1:0]   b2;
    logic [2*sgp_pkg::PosW-1:0]   t2;
    logic [2*sgp_pkg::PosW+1:0]   s2;
    logic [2*sgp_pkg::PosW:0]     d2;
    logic                         a_zero;
    logic                         b_zero;
    logic                         horiz;
    logic                         vert;
    logic [sgp_pkg::FracW-1:0]    hx;
    logic [sgp_pkg::FracW-1:0]    vy;
    logic [sgp_pkg::FracW-1:0]    dgx;

    assign sum_ab = {1'b0, i_mid.a} + {1'b0, i_mid.b};
    assign a2     = {{sgp_pkg::PosW{1'b0}}, i_mid.a} * {{sgp_pkg::PosW{1'b0}}, i_mid.a};
    assign b2     = {{sgp_pkg::PosW{1'b0}}, i_mid.b} * {{sgp_pkg::PosW{1'b0}}, i_mid.b};
    assign t2     = {{sgp_pkg::PosW{1'b0}}, i_min_distance}
                  * {{sgp_pkg::PosW{1'b0}}, i_min_distance};
    assign s2     = {{(sgp_pkg::PosW+1){1'b0}}, sum_ab} * {{(sgp_pkg::PosW+1){1'b0}}, sum_ab};
    assign d2     = {1'b0, a2} + {1'b0, b2};
    assign a_zero = i_mid.a == '0;
    assign b_zero = i_mid.b == '0;

    // The direction is within 22.5 degrees of an axis when (a+b)^2 < 2*a^2.
    assign horiz = s2 < {1'b0, a2, 1'b0};
    assign vert  = s2 < {1'b0, b2, 1'b0};

    assign hx  = i_mid.dx_neg ? sgp_pkg::FX_LOW : sgp_pkg::FX_HIGH;
    assign vy  = (!i_mid.dy_neg && !b_zero) ? sgp_pkg::FX_HIGH : sgp_pkg::FX_LOW;
    assign dgx = (!i_mid.dx_neg && !a_zero) ? sgp_pkg::FX_HIGH : sgp_pkg::FX_LOW;

    always_comb begin
        if (d2 < {1'b0, t2}) begin
            o_end.x = sgp_pkg::FX_CENTRE;
            o_end.y = sgp_pkg::FX_CENTRE;
        end else if (a_zero && b_zero) begin
            o_end.x = sgp_pkg::FX_HIGH;
            o_end.y = sgp_pkg::FX_CENTRE;
        end else if (horiz) begin
            o_end.x = hx;
            o_end.y = sgp_pkg::FX_CENTRE;
        end else if (vert) begin
            o_end.x = sgp_pkg::FX_CENTRE;
            o_end.y = vy;
        end else begin
            o_end.x = dgx;
            o_end.y = vy;
        end
    end

endmodule
`default_nettype wire

[rtl/core/sgp_player.sv]
`default_nettype none
module sgp_player #(
    parameter int unsigned HOLD_FRAMES = sgp_pkg::HoldFramesDefault
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_mid_valid,
    input  wire sgp_pkg::t_mid    i_mid,
    input  wire sgp_pkg::t_point  i_end,
    input  wire logic             i_enable,
    input  wire logic             i_out_ready,
    output logic                  o_adv,
    output logic                  o_out_valid,
    output sgp_pkg::t_result      o_result
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PRESS   = 2'd1;
    localparam logic [1:0] PH_MOVE    = 2'd2;
    localparam logic [1:0] PH_RELEASE = 2'd3;
    localparam logic [sgp_pkg::FrameW-1:0] Hold = sgp_pkg::FrameW'(HOLD_FRAMES);

    logic [1:0]                   r_phase;
    logic [1:0]                   n_phase;
    logic [sgp_pkg::FrameW-1:0]   r_frame;
    logic [sgp_pkg::FrameW-1:0]   n_frame;
    logic [sgp_pkg::FrameW-1:0]   frame_inc;
    sgp_pkg::t_point              r_end;
    sgp_pkg::t_point              n_end;
    logic                         r_out_valid;
    sgp_pkg::t_result             r_out;
    logic                         n_emit;
    sgp_pkg::t_result             n_out;
    logic                         work;

    assign o_adv     = !r_out_valid || i_out_ready;
    assign work      = i_mid_valid && o_adv;
    assign frame_inc = r_frame + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_frame = r_frame;
        n_end   = r_end;
        n_emit  = 1'b0;
        n_out.touch_down     = 1'b0;
        n_out.pos            = r_end;
        n_out.button_update  = 1'b1;
        n_out.button_pressed = 1'b0;
        case (i_mid.kind)
            sgp_pkg::K_DOWN: begin
                if (r_phase != PH_IDLE) begin
                    n_emit  = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            sgp_pkg::K_UP: begin
                n_end   = i_end;
                n_phase = PH_PRESS;
                n_frame = '0;
            end
            sgp_pkg::K_TICK: begin
                if (i_enable && r_phase != PH_IDLE) begin
                    n_emit = 1'b1;
                    if (r_phase == PH_RELEASE) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_out.touch_down = 1'b1;
                        if (r_phase == PH_PRESS) begin
                            n_out.pos.x          = sgp_pkg::FX_CENTRE;
                            n_out.pos.y          = sgp_pkg::FX_CENTRE;
                            n_out.button_pressed = 1'b1;
                        end else begin
                            n_out.button_update = 1'b0;
                        end
                        n_frame = frame_inc;
                        if (frame_inc >= Hold) begin
                            n_frame = '0;
                            n_phase = (r_phase == PH_PRESS) ? PH_MOVE : PH_RELEASE;
                        end
                    end
                end
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_frame     <= '0;
            r_end.x     <= sgp_pkg::FX_CENTRE;
            r_end.y     <= sgp_pkg::FX_CENTRE;
            r_out_valid <= 1'b0;
        end else if (work) begin
            r_phase     <= n_phase;
            r_frame     <= n_frame;
            r_end       <= n_end;
            r_out_valid <= n_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule
`default_nettype wire
